// ===== rtl/swah_pkg.sv =====
// Shared types and constants for the sensor window average history block.
package swah_pkg;

    // Number of sensor channels: temperature, pressure, humidity.
    localparam int NCH = 3;

    // Fixed widths of the stream fields.
    localparam int FIELD_W = 24;
    localparam int HOURS_W = 7;
    localparam int CMD_W   = 2;
    localparam int S_DATA_W = 72;
    localparam int S_USER_W = 8;
    localparam int M_DATA_W = 80;

    // Command codes carried in s_tuser.
    localparam logic [CMD_W-1:0] CMD_INIT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_PUSH = 2'd1;
    localparam logic [CMD_W-1:0] CMD_TICK = 2'd2;
    localparam logic [CMD_W-1:0] CMD_DAY  = 2'd3;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;     // input transaction taken this cycle
        logic sum_step;   // add one window entry per channel
        logic div_load;   // load the reciprocal multipliers from the sums
        logic div_step;   // one reciprocal multiply step
        logic avg_write;  // write the quotients to the average registers
        logic out_load;   // load the output register
    } swah_ctl_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic sum_last;   // the last window entry is being added
        logic div_last;   // the last multiply step is being taken
    } swah_stat_t;

endpackage

// ===== rtl/swah_dp.sv =====
// Datapath: window, three-hour and daily stores, summing and the window divider.
module swah_dp
    import swah_pkg::*;
#(
    parameter int WINDOW_DEPTH     = 12,
    parameter int THREE_HOUR_DEPTH = 8,
    parameter int DAY_DEPTH        = 24,
    parameter int SAMPLE_BITS      = 24
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  swah_ctl_t           ctl,
    input  logic [CMD_W-1:0]    s_cmd,
    input  logic [S_DATA_W-1:0] s_data,
    output swah_stat_t          stat,
    output logic [M_DATA_W-1:0] m_data
);

    localparam int SUM_W   = SAMPLE_BITS + $clog2(WINDOW_DEPTH) + 1;
    localparam int MAG_W   = SUM_W - 1;
    localparam int SHIFT   = MAG_W + $clog2(WINDOW_DEPTH);
    localparam int RCP_W   = MAG_W + 1;
    localparam int PART_W  = 16;
    localparam int PARTS   = (MAG_W + PART_W - 1) / PART_W;
    localparam int PAD_W   = PARTS * PART_W;
    localparam int PROD_W  = PAD_W + RCP_W;
    localparam int IDX_W   = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int CNT_MAX = (WINDOW_DEPTH > PARTS) ? WINDOW_DEPTH : PARTS;
    localparam int CNT_W   = (CNT_MAX > 1) ? $clog2(CNT_MAX) : 1;

    // Rounded-up reciprocal of the window depth, exact for any magnitude below 2**MAG_W.
    localparam logic [RCP_W-1:0] RCP =
        RCP_W'(((64'd1 << SHIFT) + 64'(WINDOW_DEPTH) - 64'd1) / 64'(WINDOW_DEPTH));

    logic signed [SAMPLE_BITS-1:0] win_reg   [NCH][WINDOW_DEPTH];
    logic signed [SAMPLE_BITS-1:0] three_reg [NCH][THREE_HOUR_DEPTH];
    logic signed [SAMPLE_BITS-1:0] day_reg   [NCH][DAY_DEPTH];
    logic signed [SAMPLE_BITS-1:0] avg_reg   [NCH];
    logic signed [SUM_W-1:0]       acc_reg   [NCH];
    logic [PAD_W-1:0]              mag_reg   [NCH];
    logic [PROD_W-1:0]             prod_reg  [NCH];
    logic [PROD_W-1:0]             prod_next [NCH];
    logic [PART_W+RCP_W-1:0]       part      [NCH];
    logic                          neg_reg   [NCH];
    logic signed [SAMPLE_BITS-1:0] sample    [NCH];
    logic signed [SAMPLE_BITS-1:0] quot      [NCH];
    logic [CNT_W-1:0]              cnt_reg;
    logic [HOURS_W-1:0]            hours_reg;
    logic [M_DATA_W-1:0]           out_reg;

    // Samples are the low SAMPLE_BITS of each field, zero-extended if wider.
    always_comb begin
        for (int c = 0; c < NCH; c++) begin
            sample[c] = SAMPLE_BITS'(s_data[c*FIELD_W +: FIELD_W]);
        end
    end

    // Division of each magnitude by the window depth through its reciprocal,
    // one 16-bit slice of the magnitude per step, most significant slice first.
    always_comb begin
        for (int c = 0; c < NCH; c++) begin
            part[c]      = (PART_W+RCP_W)'(mag_reg[c][PAD_W-1 -: PART_W]) *
                           (PART_W+RCP_W)'(RCP);
            prod_next[c] = (prod_reg[c] << PART_W) + PROD_W'(part[c]);
            quot[c]      = SAMPLE_BITS'(prod_reg[c][PROD_W-1:SHIFT]);
        end
    end

    // Step counter shared by the summing pass and the division.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else if (ctl.accept || ctl.div_load) begin
            cnt_reg <= '0;
        end else if (ctl.sum_step || ctl.div_step) begin
            cnt_reg <= cnt_reg + 1'b1;
        end
    end

    assign stat.sum_last = (cnt_reg == CNT_W'(WINDOW_DEPTH - 1));
    assign stat.div_last = (cnt_reg == CNT_W'(PARTS - 1));

    // Window stores: fill on init, shift toward index zero on push.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int c = 0; c < NCH; c++) begin
                for (int i = 0; i < WINDOW_DEPTH; i++) begin
                    win_reg[c][i] <= '0;
                end
            end
        end else if (ctl.accept && s_cmd == CMD_INIT) begin
            for (int c = 0; c < NCH; c++) begin
                for (int i = 0; i < WINDOW_DEPTH; i++) begin
                    win_reg[c][i] <= sample[c];
                end
            end
        end else if (ctl.accept && s_cmd == CMD_PUSH) begin
            for (int c = 0; c < NCH; c++) begin
                for (int i = 0; i < WINDOW_DEPTH - 1; i++) begin
                    win_reg[c][i] <= win_reg[c][i+1];
                end
                win_reg[c][WINDOW_DEPTH-1] <= sample[c];
            end
        end
    end

    // Three-hour stores: newest average enters at index zero.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int c = 0; c < NCH; c++) begin
                for (int i = 0; i < THREE_HOUR_DEPTH; i++) begin
                    three_reg[c][i] <= '0;
                end
            end
        end else if (ctl.accept && s_cmd == CMD_INIT) begin
            for (int c = 0; c < NCH; c++) begin
                for (int i = 0; i < THREE_HOUR_DEPTH; i++) begin
                    three_reg[c][i] <= sample[c];
                end
            end
        end else if (ctl.accept && s_cmd == CMD_TICK) begin
            for (int c = 0; c < NCH; c++) begin
                for (int i = 1; i < THREE_HOUR_DEPTH; i++) begin
                    three_reg[c][i] <= three_reg[c][i-1];
                end
                three_reg[c][0] <= avg_reg[c];
            end
        end
    end

    // Daily stores: newest average enters at the last index.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int c = 0; c < NCH; c++) begin
                for (int i = 0; i < DAY_DEPTH; i++) begin
                    day_reg[c][i] <= '0;
                end
            end
        end else if (ctl.accept && s_cmd == CMD_INIT) begin
            for (int c = 0; c < NCH; c++) begin
                for (int i = 0; i < DAY_DEPTH; i++) begin
                    day_reg[c][i] <= sample[c];
                end
            end
        end else if (ctl.accept && s_cmd == CMD_DAY) begin
            for (int c = 0; c < NCH; c++) begin
                for (int i = 0; i < DAY_DEPTH - 1; i++) begin
                    day_reg[c][i] <= day_reg[c][i+1];
                end
                day_reg[c][DAY_DEPTH-1] <= avg_reg[c];
            end
        end
    end

    // Hour counter saturates at the three-hour store depth.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hours_reg <= '0;
        end else if (ctl.accept && s_cmd == CMD_INIT) begin
            hours_reg <= '0;
        end else if (ctl.accept && s_cmd == CMD_TICK &&
                     hours_reg != HOURS_W'(THREE_HOUR_DEPTH)) begin
            hours_reg <= hours_reg + 1'b1;
        end
    end

    // Window sums, one entry per cycle, then the reciprocal multiply registers.
    always_ff @(posedge aclk) begin
        for (int c = 0; c < NCH; c++) begin
            if (ctl.accept) begin
                acc_reg[c] <= '0;
            end else if (ctl.sum_step) begin
                acc_reg[c] <= acc_reg[c] + SUM_W'(win_reg[c][cnt_reg[IDX_W-1:0]]);
            end
            if (ctl.div_load) begin
                neg_reg[c]  <= acc_reg[c][SUM_W-1];
                prod_reg[c] <= '0;
                mag_reg[c]  <= PAD_W'($unsigned(acc_reg[c][SUM_W-1] ? -acc_reg[c]
                                                                    : acc_reg[c]));
            end else if (ctl.div_step) begin
                prod_reg[c] <= prod_next[c];
                mag_reg[c]  <= mag_reg[c] << PART_W;
            end
        end
    end

    // Current window averages; an init window averages to its sample exactly.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int c = 0; c < NCH; c++) begin
                avg_reg[c] <= '0;
            end
        end else if (ctl.accept && s_cmd == CMD_INIT) begin
            for (int c = 0; c < NCH; c++) begin
                avg_reg[c] <= sample[c];
            end
        end else if (ctl.avg_write) begin
            for (int c = 0; c < NCH; c++) begin
                avg_reg[c] <= neg_reg[c] ? -quot[c] : quot[c];
            end
        end
    end

    // Output register holds one finished result until it is taken.
    always_ff @(posedge aclk) begin
        if (ctl.out_load) begin
            out_reg <= {1'b0, hours_reg,
                        FIELD_W'($unsigned(avg_reg[2])),
                        FIELD_W'($unsigned(avg_reg[1])),
                        FIELD_W'($unsigned(avg_reg[0]))};
        end
    end

    assign m_data = out_reg;

endmodule

// ===== rtl/swah_ctrl.sv =====
// Controller: sequences summing, division and the result handshake.
module swah_ctrl
    import swah_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    input  logic [CMD_W-1:0] s_cmd,
    input  logic             m_tready,
    input  swah_stat_t       stat,
    output logic             s_tready,
    output logic             m_tvalid,
    output swah_ctl_t        ctl
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_SUM  = 3'd1;
    localparam logic [2:0] ST_LOAD = 3'd2;
    localparam logic [2:0] ST_DIV  = 3'd3;
    localparam logic [2:0] ST_WB   = 3'd4;
    localparam logic [2:0] ST_DONE = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       slot_free;

    assign s_tready  = (state_reg == ST_IDLE);
    assign m_tvalid  = out_valid_reg;
    assign slot_free = !out_valid_reg || m_tready;

    // Next state and datapath commands.
    always_comb begin
        state_next    = state_reg;
        ctl           = '0;
        ctl.accept    = s_tvalid && s_tready;
        unique case (state_reg)
            ST_IDLE: begin
                if (ctl.accept) begin
                    state_next = (s_cmd == CMD_PUSH) ? ST_SUM : ST_DONE;
                end
            end
            ST_SUM: begin
                ctl.sum_step = 1'b1;
                if (stat.sum_last) begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD: begin
                ctl.div_load = 1'b1;
                state_next   = ST_DIV;
            end
            ST_DIV: begin
                ctl.div_step = 1'b1;
                if (stat.div_last) begin
                    state_next = ST_WB;
                end
            end
            ST_WB: begin
                ctl.avg_write = 1'b1;
                state_next    = ST_DONE;
            end
            ST_DONE: begin
                if (slot_free) begin
                    ctl.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output valid flag follows loads and completed transactions.
    always_comb begin
        if (ctl.out_load) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // A result never overwrites one that is still waiting.
    assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.out_load |-> (!out_valid_reg || m_tready))
        else $error("result loaded over a pending result");

    // A push starts the summing pass.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (ctl.accept && s_cmd == CMD_PUSH) |=> (state_reg == ST_SUM))
        else $error("push did not start summing");

    // The divider is loaded only after the last window entry was added.
    assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.div_load |-> $past(stat.sum_last && state_reg == ST_SUM))
        else $error("divider loaded before summing finished");

    // The result valid flag rises only through a load.
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(out_valid_reg) |-> $past(ctl.out_load))
        else $error("result valid without a load");

endmodule

// ===== rtl/sensor_window_average_history_core.sv =====
// Top level of the three-channel sensor window average and history block.
//
// Input channel (s_): one transaction is one command. s_tuser[1:0] holds the
// command (init, push sample, three-hour tick, day tick) and s_tdata holds the
// temperature, pressure and humidity readings. Output channel (m_): every
// command yields one transaction with the three window averages after the
// command and the saturating three-hour counter.
// Sequence: init and both ticks go from the accepting edge straight to the
// output state. A push takes one summing step per window entry, a load step,
// one multiply step per 16-bit slice of the sum magnitude (two slices at the
// default sizes), a write step and then the output state. s_tready and
// m_tvalid rise together when the result is loaded; one command is worked at
// a time.
// Reset clears every store, the averages and the counter to zero, and drops
// any pending result. When the receiver stalls, the finished result waits in
// the output register; the next command is still taken and worked, and it
// waits for the register to empty before its own result is loaded.
module sensor_window_average_history_core
    import swah_pkg::*;
#(
    parameter int WINDOW_DEPTH     = 12,
    parameter int THREE_HOUR_DEPTH = 8,
    parameter int DAY_DEPTH        = 24,
    parameter int SAMPLE_BITS      = 24
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    // sample_temp [23:0], sample_press [47:24], sample_humid [71:48]
    input  logic [S_DATA_W-1:0] s_tdata,
    // cmd [1:0], upper bits unused
    input  logic [S_USER_W-1:0] s_tuser,
    output logic                m_tvalid,
    input  logic                m_tready,
    // avg_temp_out [23:0], avg_press_out [47:24], avg_humid_out [71:48],
    // hours_recorded [78:72], bit 79 zero
    output logic [M_DATA_W-1:0] m_tdata
);

    swah_ctl_t  ctl;
    swah_stat_t stat;

    // Command sequencing and handshakes.
    swah_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_cmd    (s_tuser[CMD_W-1:0]),
        .m_tready (m_tready),
        .stat     (stat),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .ctl      (ctl)
    );

    // Stores, summing, division and the output register.
    swah_dp #(
        .WINDOW_DEPTH     (WINDOW_DEPTH),
        .THREE_HOUR_DEPTH (THREE_HOUR_DEPTH),
        .DAY_DEPTH        (DAY_DEPTH),
        .SAMPLE_BITS      (SAMPLE_BITS)
    ) u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (ctl),
        .s_cmd   (s_tuser[CMD_W-1:0]),
        .s_data  (s_tdata),
        .stat    (stat),
        .m_data  (m_tdata)
    );

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the three-channel sensor window average history core.
module tb;
    import swah_pkg::*;

    localparam int WIN_DEPTH   = 12;
    localparam int HOUR_DEPTH  = 8;
    localparam int CYCLE_LIMIT = 600000;
    localparam int MAX_REPORTS = 10;

    localparam logic [FIELD_W-1:0] S_MAX  = 24'h7FFFFF;
    localparam logic [FIELD_W-1:0] S_MIN  = 24'h800000;
    localparam logic [FIELD_W-1:0] S_ZERO = 24'h000000;
    localparam logic [FIELD_W-1:0] S_NEG1 = 24'hFFFFFF;

    typedef logic signed [FIELD_W-1:0] sample_t;

    // Result fields, ordered so the struct lines up with m_tdata[78:0].
    typedef struct packed {
        logic [HOURS_W-1:0] hours;
        sample_t            humid;
        sample_t            press;
        sample_t            temp;
    } averages_t;

    typedef enum int {RX_ALWAYS, RX_RANDOM, RX_PATTERN} rx_mode_e;

    logic                aclk     = 1'b0;
    logic                aresetn  = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata  = '0;
    logic [S_USER_W-1:0] s_tuser  = '0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;

    // Predictor state: only the windows and the hour counter reach the outputs.
    bit signed [FIELD_W-1:0] window_q [NCH][WIN_DEPTH];
    int unsigned             hours_q;
    averages_t               pending_averages [$];

    averages_t   want_avg;
    averages_t   got_avg;
    int          mismatches  = 0;
    int          cycle_count = 0;
    rx_mode_e    rx_mode     = RX_ALWAYS;
    logic        rx_hold     = 1'b0;
    logic [15:0] stall_pattern = 16'b1011_0111_0010_1110;

    sensor_window_average_history_core DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #2 aclk = ~aclk;

    // Watchdog on the total run length.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("** sensor_window_average_history_core: FAILED **");
            $finish;
        end
    end

    // Mean of one channel's window, truncated toward zero.
    function automatic sample_t window_mean(input int ch);
        longint acc;
        acc = 0;
        for (int i = 0; i < WIN_DEPTH; i++) acc += longint'(window_q[ch][i]);
        return sample_t'(acc / WIN_DEPTH);
    endfunction

    // Advance the predicted history by one command and return the averages it yields.
    function automatic averages_t apply_command(input logic [CMD_W-1:0] cmd,
                                                input logic [S_DATA_W-1:0] data);
        averages_t r;
        for (int ch = 0; ch < NCH; ch++) begin
            case (cmd)
                CMD_INIT: begin
                    for (int i = 0; i < WIN_DEPTH; i++)
                        window_q[ch][i] = data[ch*FIELD_W +: FIELD_W];
                end
                CMD_PUSH: begin
                    for (int i = 0; i < WIN_DEPTH - 1; i++)
                        window_q[ch][i] = window_q[ch][i+1];
                    window_q[ch][WIN_DEPTH-1] = data[ch*FIELD_W +: FIELD_W];
                end
                default: begin
                    // Ticks only move the long-term stores, which never reach the outputs.
                end
            endcase
        end
        if (cmd == CMD_INIT) hours_q = 0;
        else if (cmd == CMD_TICK && hours_q < HOUR_DEPTH) hours_q++;
        r.temp  = window_mean(0);
        r.press = window_mean(1);
        r.humid = window_mean(2);
        r.hours = hours_q[HOURS_W-1:0];
        return r;
    endfunction

    function automatic logic [S_DATA_W-1:0] pack_samples(input logic [FIELD_W-1:0] t,
                                                         input logic [FIELD_W-1:0] p,
                                                         input logic [FIELD_W-1:0] h);
        return {h, p, t};
    endfunction

    // Random readings with the extremes mixed in now and then.
    function automatic logic [S_DATA_W-1:0] random_samples();
        logic [S_DATA_W-1:0] d;
        for (int ch = 0; ch < NCH; ch++) begin
            case ($urandom_range(0, 15))
                0:       d[ch*FIELD_W +: FIELD_W] = S_MAX;
                1:       d[ch*FIELD_W +: FIELD_W] = S_MIN;
                2:       d[ch*FIELD_W +: FIELD_W] = S_ZERO;
                3:       d[ch*FIELD_W +: FIELD_W] = S_NEG1;
                4, 5:    d[ch*FIELD_W +: FIELD_W] = FIELD_W'($urandom_range(0, 64)) - 24'd32;
                default: d[ch*FIELD_W +: FIELD_W] = FIELD_W'($urandom);
            endcase
        end
        return d;
    endfunction

    // Mostly pushes and ticks, with the rare init restarting the history.
    function automatic logic [CMD_W-1:0] random_command();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 2) return CMD_INIT;
        else if (r < 62) return CMD_PUSH;
        else if (r < 82) return CMD_TICK;
        else return CMD_DAY;
    endfunction

    // Offer one command and record its expected averages once the transaction is taken.
    task automatic send_command(input logic [CMD_W-1:0] cmd, input logic [S_DATA_W-1:0] data);
        logic [S_USER_W-CMD_W-1:0] spare;
        spare = (S_USER_W-CMD_W)'($urandom);
        s_tvalid <= 1'b1;
        s_tdata  <= data;
        s_tuser  <= {spare, cmd};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        pending_averages.push_back(apply_command(cmd, data));
    endtask

    // Drop valid for the given number of cycles.
    task automatic pause_sender(input int cycles);
        s_tvalid <= 1'b0;
        repeat (cycles) @(posedge aclk);
    endtask

    // Hold the receiver off for the given number of cycles.
    task automatic hold_receiver(input int cycles);
        rx_hold <= 1'b1;
        repeat (cycles) @(posedge aclk);
        rx_hold <= 1'b0;
    endtask

    task automatic note_mismatch(input string what, input longint want, input longint got);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("mismatch in %s at cycle %0d: expected %0d, got %0d",
                     what, cycle_count, want, got);
    endtask

    // Receiver ready, following the current stall mode.
    always @(posedge aclk) begin
        stall_pattern <= {stall_pattern[14:0], stall_pattern[15]};
        case (rx_mode)
            RX_ALWAYS: m_tready <= !rx_hold;
            RX_RANDOM: m_tready <= !rx_hold && ($urandom_range(0, 3) != 0);
            default:   m_tready <= !rx_hold && stall_pattern[0];
        endcase
    end

    // Compare every result transaction with the oldest expectation.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_averages.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected result %h at cycle %0d", m_tdata, cycle_count);
            end else begin
                want_avg = pending_averages.pop_front();
                got_avg  = averages_t'(m_tdata[M_DATA_W-2:0]);
                if (got_avg.temp !== want_avg.temp)
                    note_mismatch("avg_temp_out", want_avg.temp, got_avg.temp);
                if (got_avg.press !== want_avg.press)
                    note_mismatch("avg_press_out", want_avg.press, got_avg.press);
                if (got_avg.humid !== want_avg.humid)
                    note_mismatch("avg_humid_out", want_avg.humid, got_avg.humid);
                if (got_avg.hours !== want_avg.hours)
                    note_mismatch("hours_recorded", want_avg.hours, got_avg.hours);
                if (m_tdata[M_DATA_W-1] !== 1'b0)
                    note_mismatch("pad bit", 0, m_tdata[M_DATA_W-1]);
            end
        end
    end

    // Full-scale readings, ignored samples on ticks, and truncation toward zero.
    task automatic test_extreme_samples();
        rx_mode <= RX_ALWAYS;
        send_command(CMD_INIT, pack_samples(S_MAX, S_MAX, S_MAX));
        send_command(CMD_DAY, random_samples());
        send_command(CMD_TICK, random_samples());
        send_command(CMD_PUSH, pack_samples(S_MIN, S_ZERO, S_MAX));
        send_command(CMD_INIT, pack_samples(S_MIN, S_MIN, S_MIN));
        send_command(CMD_PUSH, pack_samples(S_MAX, S_MAX, S_MAX));
        send_command(CMD_TICK, pack_samples(S_MAX, S_MIN, S_NEG1));
        send_command(CMD_INIT, pack_samples(S_ZERO, S_ZERO, S_ZERO));
        send_command(CMD_PUSH, pack_samples(S_NEG1, 24'd1, -24'sd13));
        send_command(CMD_PUSH, pack_samples(-24'sd11, 24'd11, S_NEG1));
        send_command(CMD_DAY, random_samples());
        pause_sender(1);
    endtask

    // The hour counter stops at the three-hour depth and init clears it.
    task automatic test_hour_saturation();
        rx_mode <= RX_PATTERN;
        send_command(CMD_INIT, random_samples());
        for (int n = 0; n < HOUR_DEPTH + 2; n++) send_command(CMD_TICK, random_samples());
        send_command(CMD_INIT, random_samples());
        pause_sender(1);
    endtask

    // Random command stream, optionally in bursts with random gaps between them.
    task automatic test_random_traffic(input int count, input rx_mode_e mode, input bit bursty);
        int burst_left;
        rx_mode <= mode;
        burst_left = $urandom_range(1, 20);
        for (int n = 0; n < count; n++) begin
            send_command(random_command(), random_samples());
            if (bursty) begin
                burst_left--;
                if (burst_left == 0) begin
                    pause_sender($urandom_range(1, 40));
                    burst_left = $urandom_range(1, 20);
                end
            end
        end
        pause_sender(1);
    endtask

    // A long receiver stall while commands keep coming, so the input backs up.
    task automatic test_output_backpressure();
        rx_mode <= RX_ALWAYS;
        fork
            hold_receiver(600);
            begin
                for (int n = 0; n < 40; n++) send_command(random_command(), random_samples());
            end
        join
        pause_sender(1);
    endtask

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_extreme_samples();
        test_hour_saturation();
        test_random_traffic(200, RX_ALWAYS, 1'b0);
        test_output_backpressure();
        test_random_traffic(420, RX_RANDOM, 1'b1);
        test_random_traffic(420, RX_PATTERN, 1'b1);

        while (pending_averages.size() != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
        if (mismatches == 0) begin
            $display("** sensor_window_average_history_core: PASSED **");
        end else begin
            $display("** sensor_window_average_history_core: FAILED **");
        end
        $finish;
    end

endmodule
